// ===== hdl/cmos_real_time_clock_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the real-time clock.
// ----------------------------------------------------------------------------
`ifndef CMOS_REAL_TIME_CLOCK_MACROS_SVH
`define CMOS_REAL_TIME_CLOCK_MACROS_SVH

// Checked at every rising edge while reset is released.
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Real-time clock package
// Types, register addresses and tables shared by the clock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  localparam int STORE_DEPTH_DEF      = 128;
  localparam int PERIOD_THRESHOLD_DEF = 1000000;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_ADV   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP2,
    ST_FIN
  } state_t;

  localparam logic [6:0] R_SEC     = 7'h00;
  localparam logic [6:0] R_SECALRM = 7'h01;
  localparam logic [6:0] R_MIN     = 7'h02;
  localparam logic [6:0] R_MINALRM = 7'h03;
  localparam logic [6:0] R_HOUR    = 7'h04;
  localparam logic [6:0] R_HOURALRM = 7'h05;
  localparam logic [6:0] R_DOW     = 7'h06;
  localparam logic [6:0] R_DOM     = 7'h07;
  localparam logic [6:0] R_MONTH   = 7'h08;
  localparam logic [6:0] R_YEAR    = 7'h09;
  localparam logic [6:0] R_STA     = 7'h0a;
  localparam logic [6:0] R_STB     = 7'h0b;
  localparam logic [6:0] R_STC     = 7'h0c;
  localparam logic [6:0] R_STD     = 7'h0d;
  localparam logic [6:0] R_CENTURY = 7'h32;

  typedef struct packed {
    logic load;
    logic exec;
    logic step2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic out_busy;
  } stat_t;

  function automatic logic [7:0] month_days(input logic [3:0] mo);
    logic [7:0] d;
    unique case (mo)
      4'd2:                      d = 8'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 8'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        d = 8'd31;
      default:                   d = 8'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rtc_ifs.sv =====
// ----------------------------------------------------------------------------
// Real-time clock channels
// Valid/ready channels for bus items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  reg_addr;
  logic [7:0]  write_data;
  logic [19:0] elapsed_us;
  modport source (output valid, action, reg_addr, write_data, elapsed_us, input ready);
  modport sink   (input valid, action, reg_addr, write_data, elapsed_us, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_raise;
  logic       irq_drop;
  modport source (output valid, read_data, irq_raise, irq_drop, input ready);
  modport sink   (input valid, read_data, irq_raise, irq_drop, output ready);
endinterface

`default_nettype wire

// ===== hdl/rtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Real-time clock controller
// Sequences each item through execute, a second step for all but writes, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  rtc_pkg::stat_t stat,
  output rtc_pkg::cmd_t  cmd
);
  import rtc_pkg::*;
  `include "cmos_real_time_clock_macros.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.act == ACT_WRITE) ? ST_FIN : ST_STEP2;
      end
      ST_STEP2: begin
        cmd.step2 = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `RTC_ASSERT(a_load_exec, cmd.load |=> cmd.exec, "accepted item was not executed")
  `RTC_ASSERT(a_exec_step, (cmd.exec && stat.act != ACT_WRITE) |=> cmd.step2, "second step skipped")
  `RTC_ASSERT(a_fin_free, cmd.fin |-> !stat.out_busy, "result loaded over a waiting one")

endmodule

`default_nettype wire

// ===== hdl/rtc_dpath.sv =====
// ----------------------------------------------------------------------------
// Real-time clock datapath
// Clock registers, general store, periodic accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_dpath #(
  parameter int STORE_DEPTH      = rtc_pkg::STORE_DEPTH_DEF,
  parameter int PERIOD_THRESHOLD = rtc_pkg::PERIOD_THRESHOLD_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  rtc_pkg::cmd_t  cmd,
  output rtc_pkg::stat_t stat,
  input  wire [1:0]      in_action,
  input  wire [6:0]      in_reg_addr,
  input  wire [7:0]      in_write_data,
  input  wire [19:0]     in_elapsed_us,
  input  wire            out_ready,
  output logic           out_valid,
  output logic [7:0]     out_read_data,
  output logic           out_irq_raise,
  output logic           out_irq_drop
);
  import rtc_pkg::*;
  `include "cmos_real_time_clock_macros.svh"

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [39:0] THR = 40'(PERIOD_THRESHOLD);
  localparam logic [39:0] ACC_MAX = '1;

  // Latched item.
  act_t        act_r;
  logic [6:0]  addr_r;
  logic [7:0]  wdata_r;
  logic [19:0] el_r;

  // Clock and status registers.
  logic [7:0] sec_r, seca_r, min_r, mina_r, hour_r, houra_r;
  logic [7:0] dow_r, dom_r, mon_r, year_r, sta_r, stb_r, stc_r, std_r, cent_r;
  logic [39:0] acc_r;
  logic [7:0]  las_r;

  logic [7:0] rdata_r;
  logic       raise_r, drop_r, spec_r;
  logic       ov_r;
  logic [7:0] ord_r;
  logic       oraise_r, odrop_r;

  // General store.
  logic [7:0]  mem [STORE_DEPTH];
  logic        vld_r [STORE_DEPTH];
  logic [7:0]  mem_q_r;
  logic        mem_v_r;
  logic [8:0]  addr_ext;
  logic [AW-1:0] idx;
  logic        in_rng;
  logic        mem_we;

  assign addr_ext = {2'b00, addr_r};
  assign idx      = addr_ext[AW-1:0];
  assign in_rng   = addr_ext < 9'(STORE_DEPTH);

  function automatic logic [7:0] to_bcd(input logic [7:0] x, input logic bin);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(x) * 16'd205;
    q = p[15:11];
    r = x - ({3'b000, q} * 8'd10);
    return bin ? x : {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] x, input logic bin);
    logic [7:0] t;
    t = {1'b0, x[7:4], 3'b000} + {3'b000, x[7:4], 1'b0} + {4'h0, x[3:0]};
    return bin ? x : t;
  endfunction

  function automatic logic [7:0] hour12(input logic [7:0] x, input logic h24);
    logic [7:0] h;
    h = x;
    if (!h24) begin
      if (x == 8'd0) h = 8'd12;
      else if (x > 8'd12) h = x - 8'd12;
    end
    return h;
  endfunction

  // Periodic accumulation, first step.
  logic [3:0]  code;
  logic [3:0]  sh;
  logic [35:0] p_add;
  logic [40:0] p_sum;
  logic [39:0] acc_add;

  always_comb begin
    code = sta_r[3:0];
    unique case (code)
      4'd1:    sh = 4'd8;
      4'd2:    sh = 4'd7;
      default: sh = 4'(5'd16 - {1'b0, code});
    endcase
    p_add   = (code == 4'd0) ? 36'd0 : ({16'd0, el_r} << sh);
    p_sum   = {1'b0, acc_r} + 41'(p_add);
    acc_add = p_sum[40] ? ACC_MAX : p_sum[39:0];
  end

  // Periodic check, second step.
  logic        per_hit;
  logic [7:0]  per_c;
  logic        per_irq;

  always_comb begin
    per_hit = acc_r >= THR;
    per_c   = stc_r;
    per_irq = 1'b0;
    if (per_hit) begin
      per_c = stc_r | 8'h40;
      if (stb_r[6] && !per_c[7]) begin
        per_c   = per_c | 8'h80;
        per_irq = 1'b1;
      end
    end
  end

  // Seconds carry chain.
  logic [7:0] t_sec, t_min, t_hour, t_dom, t_mon, t_year, t_cent, t_dow, t_mo, t_days;

  always_comb begin
    t_sec  = sec_r + 8'd1;
    t_min  = min_r;
    t_hour = hour_r;
    t_dom  = dom_r;
    t_mon  = mon_r;
    t_year = year_r;
    t_cent = cent_r;
    t_dow  = dow_r;
    t_mo   = mon_r;
    t_days = 8'd0;
    if (t_sec > 8'd59) begin
      t_sec = 8'd0;
      t_min = min_r + 8'd1;
      if (t_min > 8'd59) begin
        t_min  = 8'd0;
        t_hour = hour_r + 8'd1;
        if (t_hour > 8'd23) begin
          t_hour = 8'd0;
          t_mo   = (mon_r > 8'd12 || mon_r < 8'd1) ? 8'd1 : mon_r;
          t_days = month_days(t_mo[3:0]);
          if (year_r[1:0] == 2'b00 && t_mo == 8'd2) t_days = t_days + 8'd1;
          t_dom = dom_r + 8'd1;
          if (t_dom > t_days) begin
            t_dom = 8'd1;
            t_mo  = t_mo + 8'd1;
            if (t_mo > 8'd12) begin
              t_mo   = 8'd1;
              t_year = year_r + 8'd1;
              if (t_year > 8'd99) begin
                t_year = 8'd0;
                t_cent = cent_r + 8'd1;
              end
            end
            t_mon = t_mo;
          end
          t_dow = dow_r + 8'd1;
          if (t_dow > 8'd7 || t_dow < 8'd1) t_dow = 8'd1;
        end
      end
    end
  end

  // Alarm and update flags, run on the already advanced time.
  logic       al_match;
  logic [7:0] fl_c1, fl_c2;
  logic       fl_r1, fl_r2;

  always_comb begin
    al_match = (houra_r >= 8'hc0 || hour_r == houra_r) &&
               (mina_r >= 8'hc0 || min_r == mina_r) &&
               (seca_r >= 8'hc0 || (sec_r == seca_r && sec_r != las_r));
    fl_c1 = stc_r | (al_match ? 8'h20 : 8'h00);
    fl_r1 = al_match && stb_r[5] && !fl_c1[7];
    if (fl_r1) fl_c1 = fl_c1 | 8'h80;
    fl_c2 = fl_c1 | 8'h10;
    fl_r2 = stb_r[4] && !fl_c2[7];
    if (fl_r2) fl_c2 = fl_c2 | 8'h80;
  end

  logic [7:0] fb;
  logic spec_w;
  assign fb     = from_bcd(wdata_r, stb_r[2]);
  assign mem_we = cmd.exec && act_r == ACT_WRITE && in_rng && !spec_w;

  always_comb begin
    unique case (addr_r)
      R_SEC, R_SECALRM, R_MIN, R_MINALRM, R_HOUR, R_HOURALRM, R_DOW, R_DOM,
      R_MONTH, R_YEAR, R_STA, R_STB, R_STC, R_STD, R_CENTURY: spec_w = 1'b1;
      default: spec_w = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx] <= wdata_r;
    mem_q_r <= mem[idx];
    mem_v_r <= vld_r[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= act_t'(in_action);
      addr_r  <= in_reg_addr;
      wdata_r <= in_write_data;
      el_r    <= in_elapsed_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0; seca_r <= '0; min_r <= '0; mina_r <= '0;
      hour_r <= '0; houra_r <= '0; dow_r <= '0; dom_r <= '0;
      mon_r <= '0; year_r <= '0; sta_r <= '0; stb_r <= '0;
      stc_r <= '0; std_r <= '0; cent_r <= '0;
      acc_r <= '0;
      las_r <= 8'hff;
      for (int i = 0; i < STORE_DEPTH; i++) vld_r[i] <= 1'b0;
      rdata_r <= '0; raise_r <= 1'b0; drop_r <= 1'b0; spec_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cmd.fin) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      if (mem_we) vld_r[idx] <= 1'b1;

      if (cmd.load) begin
        rdata_r <= '0;
        raise_r <= 1'b0;
        drop_r  <= 1'b0;
      end

      if (cmd.exec) begin
        spec_r <= spec_w;
        unique case (act_r)
          ACT_READ: begin
            unique case (addr_r)
              R_SEC:      rdata_r <= to_bcd(sec_r, stb_r[2]);
              R_SECALRM:  rdata_r <= to_bcd(seca_r, stb_r[2]);
              R_MIN:      rdata_r <= to_bcd(min_r, stb_r[2]);
              R_MINALRM:  rdata_r <= to_bcd(mina_r, stb_r[2]);
              R_HOUR:     rdata_r <= to_bcd(hour12(hour_r, stb_r[1]), stb_r[2]);
              R_HOURALRM: rdata_r <= to_bcd(hour12(houra_r, stb_r[1]), stb_r[2]);
              R_DOW:      rdata_r <= to_bcd(dow_r, stb_r[2]);
              R_DOM:      rdata_r <= to_bcd(dom_r, stb_r[2]);
              R_MONTH:    rdata_r <= to_bcd(mon_r, stb_r[2]);
              R_YEAR:     rdata_r <= to_bcd(year_r, stb_r[2]);
              R_CENTURY:  rdata_r <= to_bcd(cent_r, stb_r[2]);
              R_STA:      rdata_r <= sta_r;
              R_STB:      rdata_r <= stb_r;
              R_STD:      rdata_r <= std_r;
              R_STC: begin
                rdata_r <= stc_r;
                stc_r   <= '0;
                drop_r  <= 1'b1;
                acc_r   <= acc_add;
              end
              default: rdata_r <= '0;
            endcase
          end
          ACT_WRITE: begin
            acc_r <= '0;
            unique case (addr_r)
              R_SEC:      sec_r   <= fb;
              R_SECALRM:  seca_r  <= fb;
              R_MIN:      min_r   <= fb;
              R_MINALRM:  mina_r  <= fb;
              R_HOUR:     hour_r  <= fb;
              R_HOURALRM: houra_r <= fb;
              R_DOW:      dow_r   <= fb;
              R_DOM:      dom_r   <= fb;
              R_MONTH:    mon_r   <= fb;
              R_YEAR:     year_r  <= fb;
              R_CENTURY:  cent_r  <= fb;
              R_STA:      sta_r   <= wdata_r & 8'h7f;
              R_STB:      stb_r   <= wdata_r;
              default: begin
                // Status C and D are read-only; other in-range bytes go to the store.
              end
            endcase
          end
          ACT_TICK: begin
            if (!stb_r[7]) begin
              sec_r  <= t_sec;
              min_r  <= t_min;
              hour_r <= t_hour;
              dom_r  <= t_dom;
              mon_r  <= t_mon;
              year_r <= t_year;
              cent_r <= t_cent;
              dow_r  <= t_dow;
            end
          end
          ACT_ADV: acc_r <= acc_add;
          default: ;
        endcase
      end

      if (cmd.step2) begin
        unique case (act_r)
          ACT_READ: begin
            if (addr_r == R_STC) begin
              stc_r   <= per_c;
              raise_r <= per_irq;
              if (per_hit && !stc_r[6]) acc_r <= acc_r - THR;
            end
            if (!spec_r) rdata_r <= (in_rng && mem_v_r) ? mem_q_r : 8'h00;
          end
          ACT_TICK: begin
            if (!stb_r[7]) begin
              stc_r   <= fl_c2;
              raise_r <= fl_r1 | fl_r2;
              sta_r   <= sta_r & 8'h7f;
              if (al_match) las_r <= sec_r;
            end
          end
          ACT_ADV: begin
            stc_r   <= per_c;
            raise_r <= per_irq;
            if (per_hit && !stc_r[6]) acc_r <= acc_r - THR;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      ord_r    <= rdata_r;
      oraise_r <= raise_r;
      odrop_r  <= drop_r;
    end
  end

  assign stat.act      = act_r;
  assign stat.out_busy = ov_r && !out_ready;
  assign out_valid     = ov_r;
  assign out_read_data = ord_r;
  assign out_irq_raise = oraise_r;
  assign out_irq_drop  = odrop_r;

  `RTC_ASSERT(a_fin_valid, cmd.fin |=> ov_r, "result register not loaded")
  `RTC_ASSERT(a_hold, (ov_r && !out_ready) |=> ov_r && $stable(ord_r), "waiting result changed")
  `RTC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !ov_r, "result valid after reset")

endmodule

`default_nettype wire

// ===== hdl/cmos_real_time_clock.sv =====
// ----------------------------------------------------------------------------
// CMOS real-time clock
// Register-file clock with BCD access, second updates, alarm and periodic flag.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   in_ch     sink       action, reg_addr, write_data, elapsed_us
//   out_ch    source     read_data, irq_raise, irq_drop
//
// A write goes from acceptance through the execute and hand-off steps; a read,
// a second tick and a time advance take the second step between them, needed
// by the registered store read and by the periodic and alarm checks that follow
// the first update. One item is in flight at a time, but a new item is accepted
// while the previous result still waits on out_ch. A stalled result holds the
// block in its hand-off step until it is taken. Reset is synchronous and clears
// the clock registers and store valid bits at once, so no clearing pass is needed.
`default_nettype none

module cmos_real_time_clock #(
  parameter int STORE_DEPTH      = rtc_pkg::STORE_DEPTH_DEF,
  parameter int PERIOD_THRESHOLD = rtc_pkg::PERIOD_THRESHOLD_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  rtc_in_if.sink     in_ch,
  rtc_out_if.source  out_ch
);
  import rtc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller only sequences; every register of the clock lives in the
  // datapath.
  rtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rtc_dpath #(
    .STORE_DEPTH      (STORE_DEPTH),
    .PERIOD_THRESHOLD (PERIOD_THRESHOLD)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (in_ch.action),
    .in_reg_addr   (in_ch.reg_addr),
    .in_write_data (in_ch.write_data),
    .in_elapsed_us (in_ch.elapsed_us),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_read_data (out_ch.read_data),
    .out_irq_raise (out_ch.irq_raise),
    .out_irq_drop  (out_ch.irq_drop)
  );

endmodule

`default_nettype wire

// ===== tb/sv/cmos_real_time_clock_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CMOS real-time clock testbench
// Drives bus reads, writes, one-second ticks and time advances through the
// valid/ready item channel, predicts every result item with a behavioural
// copy of the clock, and compares read data and interrupt flags per item.
// ----------------------------------------------------------------------------
`default_nettype none

module cmos_real_time_clock_test;
  import rtc_pkg::*;

  localparam int        STORE_DEPTH      = 128;
  localparam longint    PERIOD_THRESHOLD = 1000000;
  localparam longint    ACC_FULL         = 64'hFF_FFFF_FFFF;
  localparam logic [7:0] FLAG_IRQ        = 8'h80;
  localparam logic [7:0] FLAG_PERIODIC   = 8'h40;
  localparam logic [7:0] FLAG_ALARM      = 8'h20;
  localparam logic [7:0] FLAG_UPDATE     = 8'h10;
  localparam logic [7:0] DONT_CARE       = 8'hc0;
  localparam logic [7:0] B_INHIBIT       = 8'h80;
  localparam logic [7:0] B_BINARY        = 8'h04;
  localparam logic [7:0] B_24H           = 8'h02;
  localparam int        RANDOM_ITEMS     = 1350;

  // One result item as the clock returns it.
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_raise;
    logic       irq_drop;
  } rtc_result_t;

  // A row of the directed table. Where has_exp is set, the expected result is
  // the typed one rather than the predictor's.
  typedef struct packed {
    act_t        act;
    logic [6:0]  addr;
    logic [7:0]  data;
    logic [19:0] us;
    logic        has_exp;
    rtc_result_t exp;
  } bus_row_t;

  logic clk;
  logic rst_n;

  rtc_in_if  in_ch ();
  rtc_out_if out_ch ();

  cmos_real_time_clock u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the clock: register file, periodic accumulator and the second at
  // which the alarm last matched.
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_regs [STORE_DEPTH];
  longint      period_acc;
  logic [7:0]  last_alarm_sec;

  rtc_result_t expected_results [$];
  int          errors;
  int          items_taken;
  int          results_seen;
  int          irq_count;
  int          ticks_sent;

  // Values that travel with the item on the channel, for the directed rows.
  logic        cur_has_exp;
  rtc_result_t cur_exp;

  // Long stretch in the middle of the run where neither side idles.
  logic        no_idle;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
             what, got, want, results_seen);
    errors++;
  endtask

  function automatic logic [7:0] bcd_encode(input logic [7:0] x);
    int v;
    if (shadow_regs[R_STB] & B_BINARY) return x;
    v = ((int'(x) / 10) << 4) | (int'(x) % 10);
    return v[7:0];
  endfunction

  function automatic logic [7:0] bcd_decode(input logic [7:0] x);
    int v;
    if (shadow_regs[R_STB] & B_BINARY) return x;
    v = int'(x[7:4]) * 10 + int'(x[3:0]);
    return v[7:0];
  endfunction

  // Sets a status C flag; the interrupt is raised only if enabled in B and the
  // summary flag was not already set.
  function automatic logic raise_flag(input logic [7:0] flag, input logic [7:0] enable);
    shadow_regs[R_STC] = shadow_regs[R_STC] | flag;
    if ((shadow_regs[R_STB] & enable) != 0 && !shadow_regs[R_STC][7]) begin
      shadow_regs[R_STC] = shadow_regs[R_STC] | FLAG_IRQ;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic periodic_check(input logic [19:0] us);
    int     code;
    longint rate;
    longint add;
    logic   old_pf;
    logic   irq;
    code = int'(shadow_regs[R_STA][3:0]);
    irq  = 1'b0;
    if (code == 0) rate = 0;
    else rate = 65536 >> ((code < 3) ? code + 7 : code);
    add = longint'(us) * rate;
    if (add > ACC_FULL - period_acc) period_acc = ACC_FULL;
    else period_acc = period_acc + add;
    if (period_acc >= PERIOD_THRESHOLD) begin
      old_pf = shadow_regs[R_STC][6];
      irq    = raise_flag(FLAG_PERIODIC, FLAG_PERIODIC);
      if (!old_pf) period_acc = period_acc - PERIOD_THRESHOLD;
    end
    return irq;
  endfunction

  function automatic logic alarm_check();
    logic [7:0] s_alm;
    logic [7:0] m_alm;
    logic [7:0] h_alm;
    logic [7:0] sec;
    s_alm = shadow_regs[R_SECALRM];
    m_alm = shadow_regs[R_MINALRM];
    h_alm = shadow_regs[R_HOURALRM];
    sec   = shadow_regs[R_SEC];
    if (!(h_alm >= DONT_CARE || h_alm == shadow_regs[R_HOUR])) return 1'b0;
    if (!(m_alm >= DONT_CARE || m_alm == shadow_regs[R_MIN])) return 1'b0;
    if (!(s_alm >= DONT_CARE || (s_alm == sec && sec != last_alarm_sec))) return 1'b0;
    last_alarm_sec = sec;
    return raise_flag(FLAG_ALARM, FLAG_ALARM);
  endfunction

  // One-second update: carries through the calendar, then alarm and update flags.
  function automatic logic second_tick();
    logic [7:0] days_in [13];
    logic [7:0] sec, mins, hrs, dom, mon, yr, ndays, dow;
    logic       irq;
    days_in = '{8'd0, 8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
                8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31};
    if (shadow_regs[R_STB] & B_INHIBIT) return 1'b0;
    sec = shadow_regs[R_SEC] + 8'd1;
    if (sec > 8'd59) begin
      sec  = 8'd0;
      mins = shadow_regs[R_MIN] + 8'd1;
      if (mins > 8'd59) begin
        mins = 8'd0;
        hrs  = shadow_regs[R_HOUR] + 8'd1;
        if (hrs > 8'd23) begin
          hrs = 8'd0;
          mon = shadow_regs[R_MONTH];
          // A month outside the calendar is taken as January.
          if (mon > 8'd12 || mon < 8'd1) mon = 8'd1;
          yr    = shadow_regs[R_YEAR];
          ndays = days_in[mon];
          if (yr[1:0] == 2'b00 && mon == 8'd2) ndays = ndays + 8'd1;
          dom = shadow_regs[R_DOM] + 8'd1;
          if (dom > ndays) begin
            dom = 8'd1;
            mon = mon + 8'd1;
            if (mon > 8'd12) begin
              mon = 8'd1;
              yr  = yr + 8'd1;
              if (yr > 8'd99) begin
                yr = 8'd0;
                shadow_regs[R_CENTURY] = shadow_regs[R_CENTURY] + 8'd1;
              end
              shadow_regs[R_YEAR] = yr;
            end
            shadow_regs[R_MONTH] = mon;
          end
          shadow_regs[R_DOM] = dom;
          dow = shadow_regs[R_DOW] + 8'd1;
          if (dow > 8'd7 || dow < 8'd1) dow = 8'd1;
          shadow_regs[R_DOW] = dow;
        end
        shadow_regs[R_HOUR] = hrs;
      end
      shadow_regs[R_MIN] = mins;
    end
    shadow_regs[R_SEC] = sec;
    irq = alarm_check();
    irq = raise_flag(FLAG_UPDATE, FLAG_UPDATE) | irq;
    shadow_regs[R_STA] = shadow_regs[R_STA] & 8'h7f;
    return irq;
  endfunction

  // Works out the result item for one accepted bus item and updates the shadow.
  function automatic rtc_result_t clock_result(input act_t act, input logic [6:0] addr,
                                               input logic [7:0] data,
                                               input logic [19:0] us);
    rtc_result_t r;
    logic [7:0]  v;
    r = '0;
    case (act)
      ACT_READ: begin
        v = shadow_regs[addr];
        case (addr)
          R_SEC, R_SECALRM, R_MIN, R_MINALRM, R_DOW, R_DOM, R_MONTH, R_YEAR,
          R_CENTURY: v = bcd_encode(v);
          R_HOUR, R_HOURALRM: begin
            if (!(shadow_regs[R_STB] & B_24H)) begin
              if (v == 8'd0) v = 8'd12;
              else if (v > 8'd12) v = v - 8'd12;
            end
            v = bcd_encode(v);
          end
          R_STC: begin
            shadow_regs[R_STC] = 8'h00;
            r.irq_drop  = 1'b1;
            r.irq_raise = periodic_check(us);
          end
          default: ;
        endcase
        r.read_data = v;
      end
      ACT_WRITE: begin
        case (addr)
          R_SEC, R_MIN, R_HOUR, R_SECALRM, R_MINALRM, R_HOURALRM, R_DOW, R_DOM,
          R_MONTH, R_YEAR, R_CENTURY: shadow_regs[addr] = bcd_decode(data);
          R_STA: shadow_regs[addr] = data & 8'h7f;
          R_STC, R_STD: ;
          default: shadow_regs[addr] = data;
        endcase
        period_acc = 0;
      end
      ACT_TICK: r.irq_raise = second_tick();
      default:  r.irq_raise = periodic_check(us);
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: retires result items against the oldest expectation, then
  // predicts the item accepted at the same edge.
  // ---------------------------------------------------------------------------
  rtc_result_t got_result;
  rtc_result_t want_result;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", out_ch.read_data, 0);
        end else begin
          want_result = expected_results.pop_front();
          if (out_ch.read_data !== want_result.read_data)
            report_mismatch("read_data", out_ch.read_data, want_result.read_data);
          if (out_ch.irq_raise !== want_result.irq_raise)
            report_mismatch("irq_raise", out_ch.irq_raise, want_result.irq_raise);
          if (out_ch.irq_drop !== want_result.irq_drop)
            report_mismatch("irq_drop", out_ch.irq_drop, want_result.irq_drop);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        got_result = clock_result(act_t'(in_ch.action), in_ch.reg_addr,
                                  in_ch.write_data, in_ch.elapsed_us);
        if (got_result.irq_raise) irq_count++;
        if (act_t'(in_ch.action) == ACT_TICK) ticks_sent++;
        expected_results.push_back(cur_has_exp ? cur_exp : got_result);
      end
    end
  end

  // The result side stalls at random, except during the quiet stretch.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 34);
  end

  // ---------------------------------------------------------------------------
  // Driver. The gap is decided before the item is presented, so valid is set
  // at most once per edge and stays high across back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_item(input act_t act, input logic [6:0] addr, input logic [7:0] data,
                           input logic [19:0] us, input logic has_exp,
                           input rtc_result_t exp);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      in_ch.action <= 2'($urandom_range(3));
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.reg_addr   <= addr;
    in_ch.write_data <= data;
    in_ch.elapsed_us <= us;
    cur_has_exp      <= has_exp;
    cur_exp          <= exp;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  task automatic send(input act_t act, input logic [6:0] addr, input logic [7:0] data,
                      input logic [19:0] us);
    send_item(act, addr, data, us, 1'b0, '0);
  endtask

  // Encodes a small time value the way the clock expects it in the current mode.
  logic binary_mode;
  function automatic logic [7:0] time_byte(input int v);
    if (binary_mode) return 8'(v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  task automatic write_status_b(input logic [7:0] b);
    binary_mode = b[2];
    send(ACT_WRITE, R_STB, b, 20'($urandom));
  endtask

  // Directed table: after reset, calendar extremes, flags, inhibited updates.
  bus_row_t directed_rows [24];

  initial begin
    directed_rows = '{
      // After reset everything reads as zero, apart from hour 0 which reads 12.
      '{ACT_READ,  R_SEC,     8'h00, 20'h00000, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{ACT_READ,  R_HOUR,    8'h00, 20'h00000, 1'b1, '{8'h12, 1'b0, 1'b0}},
      '{ACT_READ,  R_STC,     8'h00, 20'hfffff, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{ACT_ADV,   R_SEC,     8'h00, 20'hfffff, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{ACT_WRITE, 7'h7f,     8'hff, 20'h00000, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{ACT_READ,  7'h7f,     8'h00, 20'h00000, 1'b1, '{8'hff, 1'b0, 1'b0}},
      // Last second of a century, in binary 24-hour mode.
      '{ACT_WRITE, R_STB,     8'h06, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_SEC,     8'd59, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_MIN,     8'd59, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_HOUR,    8'd23, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_DOM,     8'd31, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_MONTH,   8'd12, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_YEAR,    8'd99, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_DOW,     8'd7,  20'h00000, 1'b0, '0},
      '{ACT_TICK,  R_SEC,     8'h00, 20'h00000, 1'b0, '0},
      '{ACT_READ,  R_CENTURY, 8'h00, 20'h00000, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{ACT_READ,  R_DOW,     8'h00, 20'h00000, 1'b1, '{8'h01, 1'b0, 1'b0}},
      // All interrupts enabled, fastest periodic rate, largest time step.
      '{ACT_WRITE, R_STB,     8'h70, 20'h00000, 1'b0, '0},
      '{ACT_WRITE, R_STA,     8'hf3, 20'h00000, 1'b0, '0},
      '{ACT_ADV,   R_SEC,     8'h00, 20'hfffff, 1'b0, '0},
      '{ACT_READ,  R_STC,     8'h00, 20'h00001, 1'b0, '0},
      // Updates inhibited: the tick leaves everything alone.
      '{ACT_WRITE, R_STB,     8'hf0, 20'h00000, 1'b0, '0},
      '{ACT_TICK,  R_SEC,     8'h00, 20'h00000, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{ACT_READ,  R_STA,     8'h00, 20'h00000, 1'b1, '{8'h73, 1'b0, 1'b0}}
    };
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  int sent;
  int kind;
  int reps;
  int code;

  initial begin
    errors = 0; items_taken = 0; results_seen = 0; irq_count = 0; ticks_sent = 0;
    no_idle = 1'b0;
    binary_mode = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_regs[i] = 8'h00;
    period_acc = 0;
    last_alarm_sec = 8'hff;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_READ;
    in_ch.reg_addr = '0;
    in_ch.write_data = '0;
    in_ch.elapsed_us = '0;
    cur_has_exp = 1'b0;
    cur_exp = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].us, directed_rows[i].has_exp, directed_rows[i].exp);
    binary_mode = 1'b0;

    // Random part: mostly well-formed scenarios with random content, some noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = (sent >= 500 && sent < 750);
      kind = $urandom_range(99);
      if (kind < 10) begin
        // New mode: binary or BCD, 12 or 24 hours, enables; rarely inhibited.
        write_status_b({($urandom_range(9) == 0), 7'($urandom)});
        sent++;
      end else if (kind < 35) begin
        // Clock set close to a rollover, then a few ticks and reads.
        send(ACT_WRITE, R_SEC, time_byte($urandom_range(55, 59)), 20'($urandom));
        send(ACT_WRITE, R_MIN, time_byte($urandom_range(58, 59)), 20'($urandom));
        send(ACT_WRITE, R_HOUR, time_byte($urandom_range(22, 23)), 20'($urandom));
        send(ACT_WRITE, R_DOM, time_byte($urandom_range(27, 31)), 20'($urandom));
        send(ACT_WRITE, R_MONTH, time_byte($urandom_range(0, 13)), 20'($urandom));
        send(ACT_WRITE, R_YEAR, time_byte($urandom_range(95, 99)), 20'($urandom));
        send(ACT_WRITE, R_DOW, time_byte($urandom_range(0, 8)), 20'($urandom));
        reps = $urandom_range(2, 8);
        for (int k = 0; k < reps; k++) begin
          send(ACT_TICK, 7'($urandom), 8'($urandom), 20'($urandom));
          send(ACT_READ, 7'($urandom_range(0, 9)), 8'($urandom), 20'($urandom));
        end
        send(ACT_READ, R_CENTURY, 8'($urandom), 20'($urandom));
        sent += 8 + 2 * reps;
      end else if (kind < 50) begin
        // Alarm: exact or don't-care fields, then ticks across the match.
        send(ACT_WRITE, R_SECALRM, ($urandom_range(3) == 0) ? 8'($urandom_range(192, 255))
                                   : time_byte($urandom_range(0, 59)), 20'($urandom));
        send(ACT_WRITE, R_MINALRM, ($urandom_range(1) == 0) ? 8'hff
                                   : time_byte($urandom_range(0, 59)), 20'($urandom));
        send(ACT_WRITE, R_HOURALRM, ($urandom_range(1) == 0) ? 8'hc0
                                    : time_byte($urandom_range(0, 23)), 20'($urandom));
        reps = $urandom_range(3, 10);
        for (int k = 0; k < reps; k++) begin
          send(ACT_TICK, 7'($urandom), 8'($urandom), 20'($urandom));
          if ($urandom_range(2) == 0) send(ACT_READ, R_STC, 8'($urandom), 20'($urandom));
          else send(ACT_READ, 7'($urandom_range(0, 5)), 8'($urandom), 20'($urandom));
        end
        sent += 3 + 2 * reps;
      end else if (kind < 75) begin
        // Periodic rate, then advances and status C reads with no write between.
        send(ACT_WRITE, R_STA, 8'($urandom), 20'($urandom));
        reps = $urandom_range(2, 12);
        for (int k = 0; k < reps; k++) begin
          if ($urandom_range(3) == 0) send(ACT_READ, R_STC, 8'($urandom), 20'($urandom));
          else send(ACT_ADV, 7'($urandom), 8'($urandom), 20'($urandom));
        end
        sent += 1 + reps;
      end else if (kind < 77) begin
        // Drive the accumulator into saturation at the fastest rate.
        send(ACT_WRITE, R_STA, 8'h03, 20'($urandom));
        for (int k = 0; k < 140; k++) send(ACT_ADV, 7'($urandom), 8'($urandom), 20'hfffff);
        send(ACT_READ, R_STC, 8'($urandom), 20'hfffff);
        send(ACT_ADV, 7'($urandom), 8'($urandom), 20'($urandom));
        sent += 143;
      end else begin
        // Noise: any item at all, any register.
        code = $urandom_range(3);
        send(act_t'(code), 7'($urandom), 8'($urandom), 20'($urandom));
        if (code == ACT_WRITE) binary_mode = shadow_regs[R_STB][2];
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d items and %0d result items: %0d ticks, %0d interrupt raises.",
             items_taken, results_seen, ticks_sent, irq_count);
    if (errors == 0) begin
      $display("cmos_real_time_clock_test: done, clean");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("cmos_real_time_clock_test: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("Timed out with %0d result items still expected.", expected_results.size());
    $display("cmos_real_time_clock_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/rtc_pkg.sv
hdl/rtc_ifs.sv
hdl/rtc_ctrl.sv
hdl/rtc_dpath.sv
hdl/cmos_real_time_clock.sv
tb/sv/cmos_real_time_clock_test.sv
